/* rtl/arp_pkg.sv */
// Shared types, constants and the frame builder for the ARP responder.
// No dependencies; every module and the testbench import this package.
`default_nettype none
package arp_pkg;

   localparam int FRAME_LEN = 42;
   localparam int POS_W     = 6;
   localparam int MAC_W     = 48;
   localparam int IP_W      = 32;
   localparam int Q_DEPTH   = 2;

   localparam logic [POS_W-1:0] FRAME_LEN_C = POS_W'(FRAME_LEN);
   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LEN - 1);

   // byte positions within a received frame
   localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
   localparam logic [POS_W-1:0] POS_HTYPE_HI = 6'd14;
   localparam logic [POS_W-1:0] POS_HTYPE_LO = 6'd15;
   localparam logic [POS_W-1:0] POS_PTYPE_HI = 6'd16;
   localparam logic [POS_W-1:0] POS_PTYPE_LO = 6'd17;
   localparam logic [POS_W-1:0] POS_HLEN     = 6'd18;
   localparam logic [POS_W-1:0] POS_PLEN     = 6'd19;
   localparam logic [POS_W-1:0] POS_OPER_HI  = 6'd20;
   localparam logic [POS_W-1:0] POS_OPER_LO  = 6'd21;
   localparam logic [POS_W-1:0] POS_SHA_LO   = 6'd22;
   localparam logic [POS_W-1:0] POS_SHA_HI   = 6'd27;
   localparam logic [POS_W-1:0] POS_SPA_LO   = 6'd28;
   localparam logic [POS_W-1:0] POS_SPA_HI   = 6'd31;
   localparam logic [POS_W-1:0] POS_TPA_LO   = 6'd38;
   localparam logic [POS_W-1:0] POS_TPA_HI   = 6'd41;

   localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
   localparam logic [15:0] HTYPE_ETH     = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  HLEN_ETH      = 8'd6;
   localparam logic [7:0]  PLEN_IPV4     = 8'd4;
   localparam logic [15:0] OP_REQUEST    = 16'h0001;
   localparam logic [15:0] OP_REPLY      = 16'h0002;
   localparam logic [7:0]  BYTE_ONES     = 8'hFF;

   localparam logic [MAC_W-1:0] MAC_BROADCAST = {6{BYTE_ONES}};

   localparam logic ACTION_RX_BYTE = 1'b0;
   localparam logic ACTION_SEND    = 1'b1;

   localparam logic [0:0] CSR_OWN_MAC = 1'b0;
   localparam logic [0:0] CSR_OWN_IP  = 1'b1;

   // one frame to transmit
   typedef struct packed {
      logic             is_reply;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  ip;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic             busy;
      logic [POS_W-1:0] pos;
   } tx_status_type;

   // byte at position pos of the outgoing frame described by d
   function automatic logic [7:0] frame_byte(
      input logic [POS_W-1:0] pos,
      input desc_type         d,
      input logic [MAC_W-1:0] own_mac,
      input logic [IP_W-1:0]  own_ip
   );
      logic [0:FRAME_LEN-1][7:0] fb;
      logic [MAC_W-1:0]          dst;
      logic [MAC_W-1:0]          tmac;
      logic [15:0]               op;
      dst  = d.is_reply ? d.mac : MAC_BROADCAST;
      tmac = d.is_reply ? d.mac : '0;
      op   = d.is_reply ? OP_REPLY : OP_REQUEST;
      fb   = {dst, own_mac, ETHERTYPE_ARP, HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4,
              op, own_mac, own_ip, tmac, d.ip};
      return fb[pos];
   endfunction

endpackage
`default_nettype wire

/* rtl/arp_req_if.sv */
// Input stream channel: received bytes and send commands.
// Depends on nothing but its clockless signals.
`default_nettype none
interface arp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  rx_byte;
   logic        rx_last;
   logic [31:0] query_ip;

   modport source (output valid, output action, output rx_byte, output rx_last,
                   output query_ip, input ready);
   modport sink   (input valid, input action, input rx_byte, input rx_last,
                   input query_ip, output ready);
endinterface
`default_nettype wire

/* rtl/arp_rsp_if.sv */
// Output stream channel: bytes of transmitted ARP frames.
// Depends on nothing.
`default_nettype none
interface arp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

/* rtl/arp_responder.sv */
// ARP responder: one received byte or send command accepted per cycle while the
// two-entry frame queue has room; a full queue holds off every input transfer.
// Each queued frame leaves as 42 bytes at one byte per cycle unless the output stalls,
// frames back to back; the first byte passes through the queue entry, the transmit
// descriptor register and the output register. Synchronous active-high reset clears
// parse state, cache, queue and the transmit engine; own_mac and own_ip reset to zero.
`default_nettype none
module arp_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   arp_req_if.sink          req_chan,
   arp_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);
   import arp_pkg::*;

   logic [MAC_W-1:0] own_mac_ff, own_mac_in;
   logic [IP_W-1:0]  own_ip_ff, own_ip_in;
   push_type         push;
   logic             pop;
   desc_type         head;
   q_status_type     q_stat;
   tx_status_type    tx_stat;

   always_comb begin
      own_mac_in = own_mac_ff;
      own_ip_in  = own_ip_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_MAC: own_mac_in = csr_wdata;
            CSR_OWN_IP:  own_ip_in  = csr_wdata[IP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff  <= '0;
      end else begin
         own_mac_ff <= own_mac_in;
         own_ip_ff  <= own_ip_in;
      end
   end

   arp_rx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .own_ip   (own_ip_ff),
      .q_stat   (q_stat),
      .push     (push)
   );

   arp_desc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   arp_tx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .own_mac  (own_mac_ff),
      .own_ip   (own_ip_ff),
      .rsp_chan (rsp_chan),
      .tx_stat  (tx_stat)
   );

   // no frame is ever offered to a full queue
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !q_stat.full)
      else $error("frame pushed into full queue");

   // transmit position stays inside the frame
   assert property (@(posedge clock) disable iff (reset) tx_stat.busy |-> tx_stat.pos <= LAST_POS)
      else $error("transmit position past end of frame");

   // an idle transmitter picks up a waiting frame at once
   assert property (@(posedge clock) disable iff (reset)
      (!tx_stat.busy && !q_stat.empty) |=> tx_stat.busy)
      else $error("queued frame not started");

endmodule
`default_nettype wire

/* rtl/arp_rx_front.sv */
// Receive front end: parses incoming bytes, checks the ARP header and queues
// reply or request frames. Uses arp_pkg and arp_req_if.
`default_nettype none
module arp_rx_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   arp_req_if.sink                    req_chan,
   input  wire logic [31:0]           own_ip,
   input  wire arp_pkg::q_status_type q_stat,
   output arp_pkg::push_type          push
);
   import arp_pkg::*;

   logic [POS_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]      ether_type_ff, ether_type_in;
   logic             fixed_ok_ff, fixed_ok_in;
   logic [15:0]      opcode_ff, opcode_in;
   logic [MAC_W-1:0] peer_mac_ff, peer_mac_in;
   logic [IP_W-1:0]  peer_ip_ff, peer_ip_in;
   logic [IP_W-1:0]  asked_ip_ff, asked_ip_in;
   logic [IP_W-1:0]  cache_ip_ff, cache_ip_in;
   logic [MAC_W-1:0] cache_mac_ff, cache_mac_in;
   logic             cache_valid_ff, cache_valid_in;

   logic             accept;
   logic [7:0]       b;
   logic             good_request;

   assign req_chan.ready = !q_stat.full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.rx_byte;

   always_comb begin
      byte_count_in  = byte_count_ff;
      ether_type_in  = ether_type_ff;
      fixed_ok_in    = fixed_ok_ff;
      opcode_in      = opcode_ff;
      peer_mac_in    = peer_mac_ff;
      peer_ip_in     = peer_ip_ff;
      asked_ip_in    = asked_ip_ff;
      cache_ip_in    = cache_ip_ff;
      cache_mac_in   = cache_mac_ff;
      cache_valid_in = cache_valid_ff;
      good_request   = 1'b0;
      push.valid     = 1'b0;
      push.desc      = '0;

      if (accept && req_chan.action == ACTION_SEND) begin
         push.valid         = 1'b1;
         push.desc.is_reply = 1'b0;
         push.desc.mac      = '0;
         push.desc.ip       = req_chan.query_ip;
      end else if (accept) begin
         if (byte_count_ff < FRAME_LEN_C) begin
            priority if (byte_count_ff == POS_ETYPE_HI || byte_count_ff == POS_ETYPE_LO) begin
               ether_type_in = {ether_type_ff[7:0], b};
            end else if (byte_count_ff == POS_HTYPE_HI) begin
               if (b != HTYPE_ETH[15:8]) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_HTYPE_LO) begin
               if (b != HTYPE_ETH[7:0]) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_PTYPE_HI) begin
               if (b != PTYPE_IPV4[15:8]) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_PTYPE_LO) begin
               if (b != PTYPE_IPV4[7:0]) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_HLEN) begin
               if (b != HLEN_ETH) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_PLEN) begin
               if (b != PLEN_IPV4) fixed_ok_in = 1'b0;
            end else if (byte_count_ff == POS_OPER_HI || byte_count_ff == POS_OPER_LO) begin
               opcode_in = {opcode_ff[7:0], b};
            end else if (byte_count_ff >= POS_SHA_LO && byte_count_ff <= POS_SHA_HI) begin
               peer_mac_in = {peer_mac_ff[MAC_W-9:0], b};
            end else if (byte_count_ff >= POS_SPA_LO && byte_count_ff <= POS_SPA_HI) begin
               peer_ip_in = {peer_ip_ff[IP_W-9:0], b};
            end else if (byte_count_ff >= POS_TPA_LO && byte_count_ff <= POS_TPA_HI) begin
               asked_ip_in = {asked_ip_ff[IP_W-9:0], b};
            end else begin
               fixed_ok_in = fixed_ok_ff;
            end
            byte_count_in = byte_count_ff + 1'b1;
         end

         if (req_chan.rx_last) begin
            good_request = (byte_count_in == FRAME_LEN_C) && (ether_type_in == ETHERTYPE_ARP)
                           && fixed_ok_in && (opcode_in == OP_REQUEST)
                           && (asked_ip_in == own_ip);
            if (good_request) begin
               push.valid         = 1'b1;
               push.desc.is_reply = 1'b1;
               push.desc.mac      = peer_mac_in;
               push.desc.ip       = peer_ip_in;
               cache_ip_in        = peer_ip_in;
               cache_mac_in       = peer_mac_in;
               cache_valid_in     = 1'b1;
            end
            // end of frame: drop all parse state whatever the verdict
            byte_count_in = '0;
            ether_type_in = '0;
            fixed_ok_in   = 1'b1;
            opcode_in     = '0;
            peer_mac_in   = '0;
            peer_ip_in    = '0;
            asked_ip_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         ether_type_ff  <= '0;
         fixed_ok_ff    <= 1'b1;
         opcode_ff      <= '0;
         peer_mac_ff    <= '0;
         peer_ip_ff     <= '0;
         asked_ip_ff    <= '0;
         cache_ip_ff    <= '0;
         cache_mac_ff   <= '0;
         cache_valid_ff <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         ether_type_ff  <= ether_type_in;
         fixed_ok_ff    <= fixed_ok_in;
         opcode_ff      <= opcode_in;
         peer_mac_ff    <= peer_mac_in;
         peer_ip_ff     <= peer_ip_in;
         asked_ip_ff    <= asked_ip_in;
         cache_ip_ff    <= cache_ip_in;
         cache_mac_ff   <= cache_mac_in;
         cache_valid_ff <= cache_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/arp_desc_queue.sv */
// Two-entry queue of frame descriptors between receive and transmit sides.
// Uses arp_pkg.
`default_nettype none
module arp_desc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire arp_pkg::push_type push,
   input  wire logic              pop,
   output arp_pkg::desc_type      head,
   output arp_pkg::q_status_type  q_stat
);
   import arp_pkg::*;

   desc_type   entry_ff [Q_DEPTH];
   logic [0:0] wr_ptr_ff, wr_ptr_in;
   logic [0:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign q_stat.full  = (count_ff == 2'(Q_DEPTH));
   assign q_stat.empty = (count_ff == 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.desc;
   end

endmodule
`default_nettype wire

/* rtl/arp_tx_back.sv */
// Transmit back end: takes descriptors from the queue and streams 42-byte
// ARP frames through an output register. Uses arp_pkg and arp_rsp_if.
`default_nettype none
module arp_tx_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arp_pkg::desc_type     head,
   input  wire arp_pkg::q_status_type q_stat,
   output logic                       pop,
   input  wire logic [47:0]           own_mac,
   input  wire logic [31:0]           own_ip,
   arp_rsp_if.source                  rsp_chan,
   output arp_pkg::tx_status_type     tx_stat
);
   import arp_pkg::*;

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   desc_type         desc_ff, desc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             advance;
   logic             at_last;

   assign advance = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign at_last = (pos_ff == LAST_POS);
   assign pop     = (!busy_ff || (advance && at_last)) && !q_stat.empty;

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = frame_byte(pos_ff, desc_ff, own_mac, own_ip);
         rsp_last_in  = at_last;
         pos_in       = pos_ff + 1'b1;
         if (at_last) busy_in = 1'b0;
      end
      // load the next frame when idle, or back to back with the one just finished
      if (pop) begin
         busy_in = 1'b1;
         pos_in  = '0;
         desc_in = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;
   assign tx_stat.busy      = busy_ff;
   assign tx_stat.pos       = pos_ff;

endmodule
`default_nettype wire

/* dv/tb_arp_responder.sv */
// Self-checking testbench for arp_responder: drives received frame bytes and
// send commands, predicts every transmitted ARP frame byte and compares them.
// Depends on rtl/arp_pkg.sv, both channel interfaces and arp_responder with its submodules.
module tb_arp_responder;
   timeunit 1ns;
   timeprecision 1ps;

   import arp_pkg::*;

   localparam int         HOLD_CYCLES  = 300;
   localparam int         PHASE_ITEMS  = 16;
   localparam logic [6:0] NO_SEND      = 7'h7F;
   localparam logic [47:0] PEER_MAC    = 48'h02_11_22_33_44_55;
   localparam logic [31:0] PEER_IP     = 32'hC0A8_0102;

   typedef enum logic {ROW_FRAME, ROW_SEND} row_kind_type;
   // how the frames caused by a row are worked out
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_REPLY, EXP_REQUEST} row_exp_type;
   typedef enum logic [2:0] {
      FAULT_NONE, FAULT_ETYPE, FAULT_HTYPE, FAULT_PTYPE, FAULT_HLEN, FAULT_PLEN
   } fault_type;

   typedef struct packed {
      row_kind_type kind;
      row_exp_type  exp;
      logic [6:0]   len;
      logic [6:0]   send_pos;
      fault_type    fault;
      logic [15:0]  fault_val;
      logic [15:0]  oper;
      logic [47:0]  sha;
      logic [31:0]  spa;
      logic [31:0]  tpa;
   } arp_row_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  rx_byte;
      logic        rx_last;
      logic [31:0] query_ip;
      row_exp_type exp;
      logic [47:0] exp_mac;
      logic [31:0] exp_ip;
   } stim_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } tx_byte_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [47:0] csr_wdata;

   arp_req_if req_chan();
   arp_rsp_if rsp_chan();

   arp_responder dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // configuration and reception state of the predictor
   logic [47:0] cfg_mac;
   logic [31:0] cfg_ip;
   logic [5:0]  rx_count;
   logic [15:0] rx_etype;
   logic        rx_fields_ok;
   logic [15:0] rx_oper;
   logic [47:0] rx_sha;
   logic [31:0] rx_spa;
   logic [31:0] rx_tpa;
   logic [31:0] cache_ip;
   logic [47:0] cache_mac;
   logic        cache_valid;

   stim_type    stim_q[$];
   tx_byte_type frame_bytes_due[$];
   stim_type    offered;

   bit idle_on;
   bit hold_go;
   bit hold_rsp;
   int req_gap;
   int rsp_gap;

   int items_queued;
   int items_taken;
   int rx_frames_done;
   int sends_taken;
   int replies_due;
   int requests_due;
   int bytes_checked;
   int mismatches;

   // directed rows, run with the reset configuration (own MAC and IP zero)
   arp_row_type dir_table [0:4] = '{
      '{ROW_SEND,  EXP_REQUEST, 7'd0,  NO_SEND, FAULT_NONE, 16'h0, 16'h0, 48'h0, 32'h0,
        32'h0},
      '{ROW_SEND,  EXP_REQUEST, 7'd0,  NO_SEND, FAULT_NONE, 16'h0, 16'h0, 48'h0, 32'h0,
        32'hFFFF_FFFF},
      '{ROW_FRAME, EXP_REPLY,   7'd42, NO_SEND, FAULT_NONE, 16'h0, OP_REQUEST,
        MAC_BROADCAST, 32'hFFFF_FFFF, 32'h0},
      '{ROW_FRAME, EXP_NONE,    7'd1,  NO_SEND, FAULT_NONE, 16'h0, OP_REQUEST, PEER_MAC,
        PEER_IP, 32'h0},
      '{ROW_FRAME, EXP_PREDICT, 7'd46, 7'd43,   FAULT_NONE, 16'h0, OP_REQUEST,
        48'hA5_5A_C3_3C_0F_F0, 32'h5A5A_A5A5, 32'h0}
   };

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   task automatic log_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic void push_arp_frame(logic [47:0] dst, logic [15:0] op,
                                          logic [47:0] tmac, logic [31:0] tip);
      logic [0:FRAME_LEN-1][7:0] fb;
      int k;
      fb = {dst, cfg_mac, ETHERTYPE_ARP, HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4,
            op, cfg_mac, cfg_ip, tmac, tip};
      for (k = 0; k < FRAME_LEN; k++)
         frame_bytes_due.push_back('{data: fb[k], last: (k == FRAME_LEN - 1)});
      if (op == OP_REPLY)
         replies_due++;
      else
         requests_due++;
   endfunction

   function automatic void clear_rx();
      rx_count     = '0;
      rx_etype     = '0;
      rx_fields_ok = 1'b1;
      rx_oper      = '0;
      rx_sha       = '0;
      rx_spa       = '0;
      rx_tpa       = '0;
   endfunction

   // advance the predictor by one accepted transfer
   function automatic void step_arp_model(stim_type s);
      logic [7:0] b;
      b = s.rx_byte;
      if (s.action == ACTION_SEND) begin
         sends_taken++;
         if (s.exp == EXP_PREDICT)
            push_arp_frame(MAC_BROADCAST, OP_REQUEST, '0, s.query_ip);
      end else begin
         if (rx_count < FRAME_LEN_C) begin
            case (rx_count)
               POS_ETYPE_HI, POS_ETYPE_LO: rx_etype = {rx_etype[7:0], b};
               POS_HTYPE_HI: if (b != HTYPE_ETH[15:8]) rx_fields_ok = 1'b0;
               POS_HTYPE_LO: if (b != HTYPE_ETH[7:0]) rx_fields_ok = 1'b0;
               POS_PTYPE_HI: if (b != PTYPE_IPV4[15:8]) rx_fields_ok = 1'b0;
               POS_PTYPE_LO: if (b != PTYPE_IPV4[7:0]) rx_fields_ok = 1'b0;
               POS_HLEN:     if (b != HLEN_ETH) rx_fields_ok = 1'b0;
               POS_PLEN:     if (b != PLEN_IPV4) rx_fields_ok = 1'b0;
               POS_OPER_HI, POS_OPER_LO: rx_oper = {rx_oper[7:0], b};
               default: begin
                  if (rx_count >= POS_SHA_LO && rx_count <= POS_SHA_HI)
                     rx_sha = {rx_sha[39:0], b};
                  else if (rx_count >= POS_SPA_LO && rx_count <= POS_SPA_HI)
                     rx_spa = {rx_spa[23:0], b};
                  else if (rx_count >= POS_TPA_LO && rx_count <= POS_TPA_HI)
                     rx_tpa = {rx_tpa[23:0], b};
               end
            endcase
            rx_count = rx_count + 1'b1;
         end
         if (s.rx_last) begin
            rx_frames_done++;
            // only a well-formed request for our IP updates the cache and calls for a reply
            if (rx_count == FRAME_LEN_C && rx_etype == ETHERTYPE_ARP && rx_fields_ok &&
                rx_oper == OP_REQUEST && rx_tpa == cfg_ip) begin
               cache_ip    = rx_spa;
               cache_mac   = rx_sha;
               cache_valid = 1'b1;
               if (s.exp == EXP_PREDICT)
                  push_arp_frame(rx_sha, OP_REPLY, rx_sha, rx_spa);
            end
            clear_rx();
         end
      end
      case (s.exp)
         EXP_REPLY:   push_arp_frame(s.exp_mac, OP_REPLY, s.exp_mac, s.exp_ip);
         EXP_REQUEST: push_arp_frame(MAC_BROADCAST, OP_REQUEST, '0, s.exp_ip);
         default: ;
      endcase
   endfunction

   // expand a row into transfers on the input channel
   function automatic void queue_row(arp_row_type r);
      logic [0:FRAME_LEN-1][7:0] fb;
      logic [15:0] etype;
      logic [15:0] htype;
      logic [15:0] ptype;
      logic [7:0]  hlen;
      logic [7:0]  plen;
      stim_type    s;
      int          p;
      if (r.kind == ROW_SEND) begin
         s = '{ACTION_SEND, 8'($urandom), 1'($urandom), r.tpa, r.exp, r.sha, r.tpa};
         stim_q.push_back(s);
         items_queued++;
      end else begin
         etype = ETHERTYPE_ARP;
         htype = HTYPE_ETH;
         ptype = PTYPE_IPV4;
         hlen  = HLEN_ETH;
         plen  = PLEN_IPV4;
         case (r.fault)
            FAULT_ETYPE: etype = r.fault_val;
            FAULT_HTYPE: htype = r.fault_val;
            FAULT_PTYPE: ptype = r.fault_val;
            FAULT_HLEN:  hlen  = r.fault_val[7:0];
            FAULT_PLEN:  plen  = r.fault_val[7:0];
            default: ;
         endcase
         fb = {($urandom_range(1) != 0) ? MAC_BROADCAST : rand48(), rand48(), etype, htype,
               ptype, hlen, plen, r.oper, r.sha, r.spa, rand48(), r.tpa};
         for (p = 0; p < int'(r.len); p++) begin
            if (p == int'(r.send_pos)) begin
               s = '{ACTION_SEND, 8'($urandom), 1'($urandom), $urandom, EXP_PREDICT,
                     48'h0, 32'h0};
               stim_q.push_back(s);
               items_queued++;
            end
            s = '{ACTION_RX_BYTE, (p < FRAME_LEN) ? fb[p] : 8'($urandom),
                  p == int'(r.len) - 1, $urandom,
                  (p == int'(r.len) - 1) ? r.exp : EXP_PREDICT, r.sha, r.spa};
            stim_q.push_back(s);
            items_queued++;
         end
      end
   endfunction

   // mostly well-formed requests aimed at us, with send commands and broken and foreign frames mixed in
   function automatic arp_row_type random_row();
      arp_row_type r;
      r.kind      = ($urandom_range(4) == 0) ? ROW_SEND : ROW_FRAME;
      r.exp       = EXP_PREDICT;
      case ($urandom_range(9))
         0:       r.len = 7'($urandom_range(41, 1));
         1:       r.len = 7'($urandom_range(70, 43));
         default: r.len = 7'(FRAME_LEN);
      endcase
      r.send_pos  = ($urandom_range(4) == 0) ? 7'($urandom_range(int'(r.len) - 1)) : NO_SEND;
      r.fault     = ($urandom_range(5) == 0) ? fault_type'($urandom_range(5, 1)) : FAULT_NONE;
      r.fault_val = 16'($urandom);
      case ($urandom_range(9))
         6, 7:    r.oper = OP_REPLY;
         8:       r.oper = 16'($urandom_range(3));
         9:       r.oper = 16'($urandom);
         default: r.oper = OP_REQUEST;
      endcase
      r.sha = rand48();
      r.spa = $urandom;
      r.tpa = ($urandom_range(4) == 0 || r.kind == ROW_SEND) ? $urandom : cfg_ip;
      return r;
   endfunction

   task automatic write_csr(logic [0:0] idx, logic [47:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_OWN_MAC)
         cfg_mac = value;
      else
         cfg_ip = value[31:0];
      @(negedge clock);
   endtask

   task automatic set_config(logic [47:0] mac, logic [31:0] ip);
      write_csr(CSR_OWN_MAC, mac);
      // upper data bits are junk for the IP register
      write_csr(CSR_OWN_IP, {16'($urandom), ip});
   endtask

   task automatic run_random(int n_items);
      int start;
      start = items_queued;
      while (items_queued - start < n_items)
         queue_row(random_row());
   endtask

   // hold until every transfer is taken and every frame byte has come out
   task automatic drain();
      while (stim_q.size() != 0 || req_chan.valid || frame_bytes_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic check_tx_byte(logic [7:0] data, logic last);
      tx_byte_type due;
      bytes_checked++;
      if (frame_bytes_due.size() == 0) begin
         log_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
      end else begin
         due = frame_bytes_due.pop_front();
         if (data !== due.data)
            log_mismatch($sformatf("out_byte %02h, predicted %02h", data, due.data));
         if (last !== due.last)
            log_mismatch($sformatf("out_last %0b, predicted %0b", last, due.last));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // long receiver hold-off so the frame queue fills and input stalls
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            step_arp_model(offered);
            items_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (idle_on && $urandom_range(7) == 0) begin
               req_gap = $urandom_range(16);
               req_chan.valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
               offered = stim_q.pop_front();
               req_chan.action   <= offered.action;
               req_chan.rx_byte  <= offered.rx_byte;
               req_chan.rx_last  <= offered.rx_last;
               req_chan.query_ip <= offered.query_ip;
               req_chan.valid    <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_tx_byte(rsp_chan.out_byte, rsp_chan.out_last);
         if (rsp_gap > 0)
            rsp_gap--;
         else if (idle_on && $urandom_range(9) == 0)
            rsp_gap = $urandom_range(17, 1);
         rsp_chan.ready <= !hold_rsp && rsp_gap == 0;
      end
   end

   initial begin
      arp_row_type r;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_OWN_MAC;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.action   = ACTION_RX_BYTE;
      req_chan.rx_byte  = '0;
      req_chan.rx_last  = 1'b0;
      req_chan.query_ip = '0;
      rsp_chan.ready    = 1'b0;
      idle_on           = 1'b1;
      hold_go           = 1'b0;
      hold_rsp          = 1'b0;
      cfg_mac           = '0;
      cfg_ip            = '0;
      cache_ip          = '0;
      cache_mac         = '0;
      cache_valid       = 1'b0;
      clear_rx();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[i])
         queue_row(dir_table[i]);
      drain();

      set_config(MAC_BROADCAST, 32'hFFFF_FFFF);
      run_random(PHASE_ITEMS);
      drain();

      set_config(rand48(), $urandom);
      hold_go = 1'b1;
      repeat (6) begin
         r = random_row();
         r.kind = ROW_SEND;
         queue_row(r);
      end
      run_random(PHASE_ITEMS);
      drain();

      // no idling on either side from here on
      idle_on = 1'b0;
      set_config(rand48(), $urandom);
      run_random(PHASE_ITEMS);
      drain();

      $display("Took %0d input transfers: %0d received frames closed, %0d send commands.",
               items_taken, rx_frames_done, sends_taken);
      $display("Checked %0d output bytes (%0d replies, %0d requests), %0d mismatches.",
               bytes_checked, replies_due, requests_due, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
